// ===== sv/actr_pkg.sv =====
`default_nettype none
package actr_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned KsDepth    = 2;

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_NONCE_HIGH = 2'd2,
    REG_NONCE_LOW  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ENG_IDLE = 3'b001,
    ENG_RUN  = 3'b010,
    ENG_DONE = 3'b100
  } eng_state_e;

  typedef struct packed {
    logic         start;
    logic [127:0] key;
    logic [127:0] block;
  } eng_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] result;
  } eng_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== sv/actr_if.sv =====
`default_nettype none
interface actr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] out_byte;
  modport source (output valid, output data_byte, output out_byte, input ready);
  modport sink (input valid, input data_byte, input out_byte, output ready);
endinterface

interface actr_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/actr_engine.sv =====
`default_nettype none
// iterative aes-128, one round per cycle
module actr_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire actr_pkg::eng_req_t req_i,
  output actr_pkg::eng_rsp_t     rsp_o
);
  actr_pkg::eng_state_e state_q, state_d;
  logic [127:0] st_q, st_d, rk_q, rk_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [7:0]   rkb [16];
  logic [7:0]   nk [16];
  logic [127:0] round_out, next_rk;

  // byte i sits at bits 127-8i
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i]  = actr_pkg::sbox(st_q[127-8*i -: 8]);
      rkb[i] = rk_q[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r+4*c] = sb[r + 4*((c+r) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] t;
      t = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c]   = sr[4*c]   ^ t ^ actr_pkg::xtime(sr[4*c]   ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ t ^ actr_pkg::xtime(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ t ^ actr_pkg::xtime(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ t ^ actr_pkg::xtime(sr[4*c+3] ^ sr[4*c]);
    end
    nk[0] = rkb[0] ^ actr_pkg::sbox(rkb[13]) ^ rcon_q;
    nk[1] = rkb[1] ^ actr_pkg::sbox(rkb[14]);
    nk[2] = rkb[2] ^ actr_pkg::sbox(rkb[15]);
    nk[3] = rkb[3] ^ actr_pkg::sbox(rkb[12]);
    for (int i = 4; i < 16; i++) begin
      nk[i] = rkb[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      next_rk[127-8*i -: 8]   = nk[i];
      round_out[127-8*i -: 8] = ((rnd_q == 4'd10) ? sr[i] : mc[i]) ^ nk[i];
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    rk_d    = rk_q;
    rcon_d  = rcon_q;
    rnd_d   = rnd_q;
    case (state_q)
      actr_pkg::ENG_IDLE, actr_pkg::ENG_DONE: begin
        if (req_i.start) begin
          st_d    = req_i.block ^ req_i.key;
          rk_d    = req_i.key;
          rcon_d  = 8'h01;
          rnd_d   = 4'd1;
          state_d = actr_pkg::ENG_RUN;
        end
      end
      actr_pkg::ENG_RUN: begin
        st_d   = round_out;
        rk_d   = next_rk;
        rcon_d = actr_pkg::xtime(rcon_q);
        rnd_d  = rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          state_d = actr_pkg::ENG_DONE;
        end
      end
      default: state_d = actr_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= actr_pkg::ENG_IDLE;
      rnd_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    rk_q   <= rk_d;
    rcon_q <= rcon_d;
  end

  assign rsp_o.done   = (state_q == actr_pkg::ENG_RUN) && (rnd_q == 4'd10);
  assign rsp_o.result = round_out;
endmodule
`default_nettype wire

// ===== sv/actr_keygen.sv =====
`default_nettype none
// keystream front: runs the engine ahead, keeps a two-block queue
module actr_keygen (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         reload_i,
  input  wire logic [127:0] key_i,
  input  wire logic [127:0] nonce_i,
  input  wire logic         pop_i,
  output logic              avail_o,
  output logic [127:0]      head_o
);
  actr_pkg::eng_req_t req;
  actr_pkg::eng_rsp_t rsp;
  logic [127:0] ctr_q;
  logic [127:0] q_mem [actr_pkg::KsDepth];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         inflight_q;
  logic         discard_q;
  logic         push;

  actr_engine u_engine (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  // a reload drops any block still in the engine
  assign push = rsp.done && !discard_q && !reload_i;
  assign req.start = !reload_i && !inflight_q &&
                     ({1'b0, cnt_q} + {2'b0, pop_i} <= 3'd1 + {2'b0, pop_i}) &&
                     (cnt_q < 2'd2);
  assign req.key   = key_i;
  assign req.block = ctr_q;
  assign avail_o   = (cnt_q != 2'd0);
  assign head_o    = q_mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q      <= '0;
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
      cnt_q      <= 2'd0;
      inflight_q <= 1'b0;
      discard_q  <= 1'b0;
    end else if (reload_i) begin
      ctr_q      <= nonce_i;
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
      cnt_q      <= 2'd0;
      discard_q  <= inflight_q && !rsp.done;
      inflight_q <= inflight_q && !rsp.done;
    end else begin
      if (req.start) begin
        ctr_q      <= ctr_q + 128'd1;
        inflight_q <= 1'b1;
      end else if (rsp.done) begin
        inflight_q <= 1'b0;
        discard_q  <= 1'b0;
      end
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= rsp.result;
  end
endmodule
`default_nettype wire

// ===== sv/aes_ctr_stream_cipher.sv =====
`default_nettype none
// aes-128 counter-mode byte cipher. every input word is xored with the next
// keystream byte, taken most significant byte first from e_k(counter); the
// counter starts at {nonce_high, nonce_low} and steps by one (wrapping) per
// block. any write to registers 0..3 reloads the counter and restarts at byte
// zero of a fresh block; writes beyond 3 are ignored. the aes engine does one
// round per cycle, and the two-deep keystream queue keeps it running ahead:
// sustained rate is one word per cycle while the output is not stalled.
// after reset or a register write the first word waits for a fresh block,
// and a block still in the engine has to be dropped before that one starts.
module aes_ctr_stream_cipher (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  actr_cfg_if.sink     cfg_i,
  actr_byte_if.sink    in_i,
  actr_byte_if.source  out_o
);
  logic [63:0]  key_high_q, key_low_q, nonce_high_q, nonce_low_q;
  logic         cfg_hit, reload;
  logic [3:0]   pos_q;
  logic         avail;
  logic [127:0] head;
  logic         in_fire, pop;
  logic         out_valid_q;
  logic [7:0]   out_byte_q;
  logic [7:0]   ks_byte;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid && (cfg_i.index[63:2] == '0);
  assign reload  = cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q   <= '0;
      key_low_q    <= '0;
      nonce_high_q <= '0;
      nonce_low_q  <= '0;
    end else if (cfg_hit) begin
      case (actr_pkg::reg_idx_e'(cfg_i.index[1:0]))
        actr_pkg::REG_KEY_HIGH:   key_high_q   <= cfg_i.value;
        actr_pkg::REG_KEY_LOW:    key_low_q    <= cfg_i.value;
        actr_pkg::REG_NONCE_HIGH: nonce_high_q <= cfg_i.value;
        actr_pkg::REG_NONCE_LOW:  nonce_low_q  <= cfg_i.value;
        default: ;
      endcase
    end
  end

  // keystream generator sees the new register values in the cycle after the write
  logic reload_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) reload_q <= 1'b1;
    else         reload_q <= reload;
  end

  actr_keygen u_keygen (
    .clk_i, .rst_ni,
    .reload_i (reload_q),
    .key_i    ({key_high_q, key_low_q}),
    .nonce_i  ({nonce_high_q, nonce_low_q}),
    .pop_i    (pop),
    .avail_o  (avail),
    .head_o   (head)
  );

  // output register decouples the two sides
  assign in_i.ready = avail && !reload_q && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign pop        = in_fire && (pos_q == 4'(actr_pkg::BlockBytes - 1));
  assign ks_byte    = head[127 - 8*pos_q -: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (reload)       pos_q <= 4'd0;
      else if (in_fire) pos_q <= pos_q + 4'd1;
      if (in_fire)           out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_byte_q <= in_i.data_byte ^ ks_byte;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.data_byte = out_byte_q;

  // word position only moves on an accepted word or a reload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && !reload) |=> $stable(pos_q)) else $error("position moved");
  // a word is only taken with keystream present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> avail) else $error("word taken without keystream");
  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(out_o.out_byte)) else $error("result changed");
endmodule
`default_nettype wire
